[sv/ldc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc_pkg
// Shared types and constants for the line digraph checker: command codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package ldc_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int CNT_W            = 7;
  localparam logic [CNT_W-1:0] VC_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RD_TAIL = 2'd0,
    RD_I    = 2'd1,
    RD_J    = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ARC_WR  = 3'd1,
    ST_EV_I    = 3'd2,
    ST_EV_J    = 3'd3,
    ST_EV_SCAN = 3'd4,
    ST_EV_NEXT = 3'd5,
    ST_RESULT  = 3'd6
  } state_e;

  typedef struct packed {
    logic    clear;
    logic    latch_arc;
    logic    arc_wr;
    logic    eval_init;
    logic    j_from_i;
    logic    ld_ri;
    logic    rd_j;
    logic    i_inc;
    logic    out_load;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic arc_in_range;
    logic n_lt2;
    logic j_last;
    logic i_last;
    logic out_free;
  } dp_sts_t;

endpackage

[sv/ldc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc_dp
// Datapath: adjacency row memory with per-row valid bits, arc update,
// pairwise row compare, vertex count register and the result register.
// ----------------------------------------------------------------------------
module ldc_dp #(
  parameter int MAX_VERTICES = ldc_pkg::MAX_VERTICES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ldc_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic [5:0]             tail_vertex_i,
  input  logic [5:0]             head_vertex_i,
  input  ldc_pkg::dp_cmd_t       cmd_i,
  output ldc_pkg::dp_sts_t       sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   is_simple_o,
  output logic                   neighbourhoods_ok_o,
  output logic                   is_line_digraph_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = ldc_pkg::CNT_W;

  typedef logic [CW-1:0]           cnt_t;
  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [AW-1:0]           addr_t;

  cnt_t  vc_q;
  cnt_t  n_eff;
  row_t  col_mask;

  row_t  mem_q [MAX_VERTICES];
  row_t  row_vld_q;
  row_t  rd_data_q;
  logic  rd_vld_q;
  addr_t rd_addr;
  row_t  row_cur;
  row_t  row_msk;
  row_t  head_bit;
  logic  hit;

  addr_t tail_q, head_q;
  addr_t i_q, j_q;
  row_t  ri_q;
  logic  cmp_pend_q;
  logic  conflict;
  logic  bad_q;
  logic  multi_q;

  logic  out_valid_q;
  logic  out_simple_q, out_ok_q, out_line_q;
  logic  out_free;

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= ldc_pkg::VC_RESET;
    end else if (cfg_we_i) begin
      vc_q <= cfg_wdata_i;
    end
  end

  assign n_eff = (vc_q > cnt_t'(MAX_VERTICES)) ? cnt_t'(MAX_VERTICES) : vc_q;

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      col_mask[k] = (cnt_t'(k) < n_eff);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      ldc_pkg::RD_TAIL: rd_addr = tail_vertex_i[AW-1:0];
      ldc_pkg::RD_I:    rd_addr = i_q;
      ldc_pkg::RD_J:    rd_addr = j_q;
      default:          rd_addr = tail_vertex_i[AW-1:0];
    endcase
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.arc_wr) begin
      mem_q[tail_q] <= row_cur | head_bit;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // rows never written since the last clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[rd_addr];
      if (cmd_i.clear) begin
        row_vld_q <= '0;
      end else if (cmd_i.arc_wr) begin
        row_vld_q[tail_q] <= 1'b1;
      end
    end
  end

  assign row_cur  = rd_vld_q ? rd_data_q : '0;
  assign row_msk  = row_cur & col_mask;
  assign head_bit = row_t'(1) << head_q;
  assign hit      = row_cur[head_q];
  assign conflict = (|(ri_q & row_msk)) && (ri_q != row_msk);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_arc) begin
      tail_q <= tail_vertex_i[AW-1:0];
      head_q <= head_vertex_i[AW-1:0];
    end
    if (cmd_i.ld_ri) begin
      ri_q <= row_msk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q        <= '0;
      j_q        <= '0;
      cmp_pend_q <= 1'b0;
      bad_q      <= 1'b0;
      multi_q    <= 1'b0;
    end else begin
      cmp_pend_q <= cmd_i.rd_j;
      if (cmd_i.eval_init) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + addr_t'(1);
      end
      if (cmd_i.j_from_i) begin
        j_q <= i_q + addr_t'(1);
      end else if (cmd_i.rd_j) begin
        j_q <= j_q + addr_t'(1);
      end
      if (cmd_i.eval_init) begin
        bad_q <= 1'b0;
      end else if (cmp_pend_q && conflict) begin
        bad_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        multi_q <= 1'b0;
      end else if (cmd_i.arc_wr && hit) begin
        multi_q <= 1'b1;
      end
    end
  end

  // result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_simple_q <= !multi_q;
      out_ok_q     <= !bad_q;
      out_line_q   <= !multi_q && !bad_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign is_simple_o         = out_simple_q;
  assign neighbourhoods_ok_o = out_ok_q;
  assign is_line_digraph_o   = out_line_q;

  assign sts_o.arc_in_range = ({1'b0, tail_vertex_i} < n_eff) && ({1'b0, head_vertex_i} < n_eff);
  assign sts_o.n_lt2        = (n_eff < cnt_t'(2));
  assign sts_o.j_last       = (cnt_t'(j_q) + cnt_t'(1) >= n_eff);
  assign sts_o.i_last       = (cnt_t'(i_q) + cnt_t'(2) >= n_eff);
  assign sts_o.out_free     = out_free;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (!multi_q && row_vld_q == '0))
    else $error("clear left state behind");

  a_arc_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.arc_wr |=> row_vld_q[$past(tail_q)])
    else $error("written row not marked valid");

  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_line_q == (out_simple_q && out_ok_q)))
    else $error("line flag disagrees with its parts");

endmodule

[sv/ldc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc_ctrl
// Controller: takes input items, sequences arc updates and the pairwise
// row scan for evaluate, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ldc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  input  ldc_pkg::dp_sts_t sts_i,
  output ldc_pkg::dp_cmd_t cmd_o
);

  ldc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.rd_sel = ldc_pkg::RD_TAIL;
    case (state_q)
      ldc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (ldc_pkg::cmd_e'(command_i))
            ldc_pkg::CMD_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            ldc_pkg::CMD_ADD: begin
              // row read of the tail goes out with the item
              cmd_o.latch_arc = 1'b1;
              if (sts_i.arc_in_range) begin
                state_d = ldc_pkg::ST_ARC_WR;
              end
            end
            ldc_pkg::CMD_EVAL: begin
              cmd_o.eval_init = 1'b1;
              state_d = sts_i.n_lt2 ? ldc_pkg::ST_RESULT : ldc_pkg::ST_EV_I;
            end
            default: ;
          endcase
        end
      end
      ldc_pkg::ST_ARC_WR: begin
        cmd_o.arc_wr = 1'b1;
        state_d      = ldc_pkg::ST_IDLE;
      end
      ldc_pkg::ST_EV_I: begin
        cmd_o.rd_sel   = ldc_pkg::RD_I;
        cmd_o.j_from_i = 1'b1;
        state_d        = ldc_pkg::ST_EV_J;
      end
      ldc_pkg::ST_EV_J: begin
        cmd_o.ld_ri  = 1'b1;
        cmd_o.rd_sel = ldc_pkg::RD_J;
        cmd_o.rd_j   = 1'b1;
        state_d = sts_i.j_last ? ldc_pkg::ST_EV_NEXT : ldc_pkg::ST_EV_SCAN;
      end
      ldc_pkg::ST_EV_SCAN: begin
        // compare of the previous row happens in the datapath this cycle
        cmd_o.rd_sel = ldc_pkg::RD_J;
        cmd_o.rd_j   = 1'b1;
        if (sts_i.j_last) begin
          state_d = ldc_pkg::ST_EV_NEXT;
        end
      end
      ldc_pkg::ST_EV_NEXT: begin
        if (sts_i.i_last) begin
          state_d = ldc_pkg::ST_RESULT;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = ldc_pkg::ST_EV_I;
        end
      end
      ldc_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ldc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ldc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/line_digraph_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_digraph_check
// Loads a digraph arc by arc and checks on request whether it is a line
// digraph: simple, and every two out-neighborhoods disjoint or equal.
// ----------------------------------------------------------------------------
// Operation: a clear item is done in the idle state; an add-arc item does a row
// read, then a row write through the write port of the row memory; a dropped
// arc or an unused command is taken in the idle state and writes no row.
// Evaluate compares every pair of rows among the effective vertices; the scan reads
// one row per cycle through the one read port of the row memory and
// compares it against a held row. The result sits in an output register, so
// the next item is taken while an evaluate result waits. No clearing pass
// is needed after reset; per-row valid bits make a clear take effect at once.
module line_digraph_check #(
  parameter int MAX_VERTICES = ldc_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ldc_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                command_i,
  input  logic [5:0]                tail_vertex_i,
  input  logic [5:0]                head_vertex_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      is_simple_o,
  output logic                      neighbourhoods_ok_o,
  output logic                      is_line_digraph_o
);

  ldc_pkg::dp_cmd_t cmd;
  ldc_pkg::dp_sts_t sts;

  ldc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ldc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .tail_vertex_i       (tail_vertex_i),
    .head_vertex_i       (head_vertex_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .is_simple_o         (is_simple_o),
    .neighbourhoods_ok_o (neighbourhoods_ok_o),
    .is_line_digraph_o   (is_line_digraph_o)
  );

endmodule

[test/line_digraph_check_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_digraph_check_tb
// Self-checking bench for the line digraph checker. Arcs are loaded through
// the item channel, and every evaluate verdict is compared with a verdict
// computed from a shadow copy of the adjacency rows, the repeat-arc flag and
// the vertex count. A short directed part is followed by random graphs built
// to be line digraphs and then perturbed. The sender runs in bursts and the
// receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module line_digraph_check_tb;

  localparam logic [1:0]  CMD_NONE      = 2'd3;  // unused code, ignored by the block
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 20_000_000;

  typedef struct packed {
    logic simple;
    logic nbr_ok;
    logic line;
  } verdict_t;

  typedef enum int {
    RX_OPEN,
    RX_SPARSE,
    RX_TOGGLE,
    RX_BLOCKS
  } rx_mode_e;

  class digraph_scoreboard;
    bit [63:0]   arc_rows [64];
    bit          repeat_arc;
    bit [6:0]    vertex_count;
    verdict_t    pending_verdicts [$];
    int unsigned mismatches;
    int unsigned verdicts_checked;

    function new();
      foreach (arc_rows[i]) arc_rows[i] = '0;
      repeat_arc       = 1'b0;
      vertex_count     = ldc_pkg::VC_RESET;
      mismatches       = 0;
      verdicts_checked = 0;
    endfunction

    function void set_vertex_count(bit [6:0] value);
      vertex_count = value;
    endfunction

    function int unsigned active_vertices();
      return (vertex_count > 7'd64) ? 64 : int'(vertex_count);
    endfunction

    // Simple, and every two out-neighborhoods either disjoint or equal.
    function verdict_t adjoint_verdict();
      verdict_t    v;
      int unsigned n;
      bit [63:0]   mask;
      bit [63:0]   ri;
      bit [63:0]   rj;
      bit          ok;
      n    = active_vertices();
      mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      ok   = 1'b1;
      for (int i = 0; i < n; i++) begin
        ri = arc_rows[i] & mask;
        for (int j = i + 1; j < n; j++) begin
          rj = arc_rows[j] & mask;
          if ((ri & rj) != '0 && ri != rj) ok = 1'b0;
        end
      end
      v.simple = ~repeat_arc;
      v.nbr_ok = ok;
      v.line   = ~repeat_arc & ok;
      return v;
    endfunction

    function void note_item(logic [1:0] cmd, logic [5:0] tail, logic [5:0] head);
      int unsigned n;
      n = active_vertices();
      case (cmd)
        ldc_pkg::CMD_CLEAR: begin
          foreach (arc_rows[i]) arc_rows[i] = '0;
          repeat_arc = 1'b0;
        end
        ldc_pkg::CMD_ADD: begin
          if (tail < n && head < n) begin
            if (arc_rows[tail][head]) repeat_arc = 1'b1;
            arc_rows[tail][head] = 1'b1;
          end
        end
        ldc_pkg::CMD_EVAL: pending_verdicts.push_back(adjoint_verdict());
        default: ;
      endcase
    endfunction

    function void check_verdict(logic simple, logic nbr_ok, logic line);
      verdict_t exp_v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict with none pending: expected none, actual %b%b%b",
                 $time, simple, nbr_ok, line);
        mismatches++;
        return;
      end
      exp_v = pending_verdicts.pop_front();
      verdicts_checked++;
      if (simple !== exp_v.simple) begin
        $display("%0t: is_simple mismatch: expected %b, actual %b",
                 $time, exp_v.simple, simple);
        mismatches++;
      end
      if (nbr_ok !== exp_v.nbr_ok) begin
        $display("%0t: neighbourhoods_ok mismatch: expected %b, actual %b",
                 $time, exp_v.nbr_ok, nbr_ok);
        mismatches++;
      end
      if (line !== exp_v.line) begin
        $display("%0t: is_line_digraph mismatch: expected %b, actual %b",
                 $time, exp_v.line, line);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [ldc_pkg::CNT_W-1:0] cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [1:0]                command_i;
  logic [5:0]                tail_vertex_i;
  logic [5:0]                head_vertex_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      is_simple_o;
  logic                      neighbourhoods_ok_o;
  logic                      is_line_digraph_o;

  digraph_scoreboard sb = new();
  int unsigned       burst_left;
  int unsigned       sent_items;
  int unsigned       cycle_count;

  line_digraph_check u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .command_i           (command_i),
    .tail_vertex_i       (tail_vertex_i),
    .head_vertex_i       (head_vertex_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .is_simple_o         (is_simple_o),
    .neighbourhoods_ok_o (neighbourhoods_ok_o),
    .is_line_digraph_o   (is_line_digraph_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** line_digraph_check: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_verdict(is_simple_o, neighbourhoods_ok_o, is_line_digraph_o);
  end

  // Receiver: ready pattern switches at random between open, sparse, toggle and block modes.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned hold;
    out_ready_i = 1'b0;
    hold        = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:   out_ready_i = 1'b1;
          RX_SPARSE: out_ready_i = ($urandom_range(0, 3) == 0);
          RX_TOGGLE: out_ready_i = ~out_ready_i;
          default: begin
            if (hold == 0) begin
              out_ready_i = ~out_ready_i;
              hold        = $urandom_range(1, 15);
            end else begin
              hold--;
            end
          end
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [5:0] tail, logic [5:0] head);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    = 1'b1;
    command_i     = cmd;
    tail_vertex_i = tail;
    head_vertex_i = head;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(cmd, tail, head);
    if (cmd != CMD_NONE) sent_items++;
  endtask

  // Sender stops until every pending verdict is out and the block is quiet.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(logic [ldc_pkg::CNT_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_vertex_count(value);
  endtask

  task automatic run_directed_cases();
    send_item(ldc_pkg::CMD_EVAL, 6'd0, 6'd0);     // empty graph
    send_item(ldc_pkg::CMD_ADD, 6'd63, 6'd63);    // self loop on the top vertex
    send_item(ldc_pkg::CMD_ADD, 6'd0, 6'd63);
    send_item(ldc_pkg::CMD_ADD, 6'd63, 6'd0);
    send_item(ldc_pkg::CMD_EVAL, 6'd63, 6'd63);   // overlapping, unequal rows
    send_item(ldc_pkg::CMD_ADD, 6'd0, 6'd63);     // repeated arc
    send_item(CMD_NONE, 6'd63, 6'd63);
    send_item(ldc_pkg::CMD_EVAL, 6'd0, 6'd0);
    send_item(ldc_pkg::CMD_CLEAR, 6'd63, 6'd0);
    send_item(ldc_pkg::CMD_ADD, 6'd1, 6'd2);
    send_item(ldc_pkg::CMD_ADD, 6'd3, 6'd2);
    send_item(ldc_pkg::CMD_EVAL, 6'd0, 6'd63);
    write_vertex_count(7'd0);                     // empty graph, every arc dropped
    send_item(ldc_pkg::CMD_ADD, 6'd0, 6'd0);
    send_item(ldc_pkg::CMD_EVAL, 6'd0, 6'd0);
    write_vertex_count(7'd127);                   // saturates to the full size
    send_item(ldc_pkg::CMD_ADD, 6'd42, 6'd21);
    send_item(ldc_pkg::CMD_ADD, 6'd21, 6'd42);
    send_item(ldc_pkg::CMD_EVAL, 6'd0, 6'd0);
    write_vertex_count(7'd4);                     // shrink without clearing
    send_item(ldc_pkg::CMD_ADD, 6'd5, 6'd1);
    send_item(ldc_pkg::CMD_ADD, 6'd1, 6'd5);
    send_item(ldc_pkg::CMD_ADD, 6'd2, 6'd3);
    send_item(ldc_pkg::CMD_ADD, 6'd2, 6'd2);
    send_item(ldc_pkg::CMD_EVAL, 6'd0, 6'd0);
    write_vertex_count(7'd1);
    send_item(ldc_pkg::CMD_ADD, 6'd0, 6'd0);
    send_item(ldc_pkg::CMD_ADD, 6'd0, 6'd0);
    send_item(ldc_pkg::CMD_EVAL, 6'd0, 6'd0);
  endtask

  function automatic logic [ldc_pkg::CNT_W-1:0] pick_vertex_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 7'($urandom_range(64, 127));
    if (r == 1) return 7'd1;
    if (r == 2) return 7'd0;
    return 7'($urandom_range(2, 10));
  endfunction

  // Builds a line digraph: heads are owned by groups, each vertex points at
  // exactly the heads of its group. Then a few perturbations are mixed in.
  task automatic run_graph_episode();
    int unsigned n;
    int unsigned groups;
    int unsigned row_group [64];
    int unsigned head_group [64];
    bit          owned;
    bit [11:0]   arcs [$];
    bit [11:0]   tmp;
    int unsigned k;
    logic [5:0]  a;
    logic [5:0]  b;
    n = sb.active_vertices();
    if ($urandom_range(0, 4) != 0)
      send_item(ldc_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom));
    if (n != 0) begin
      groups = (n > 16) ? $urandom_range(16, n) : $urandom_range(1, n);
      for (int v = 0; v < n; v++) begin
        row_group[v]  = $urandom_range(0, groups - 1);
        owned = (n > 16) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 2) != 0);
        head_group[v] = owned ? $urandom_range(0, groups - 1) : groups;
      end
      for (int t = 0; t < n; t++)
        for (int h = 0; h < n; h++)
          if (head_group[h] == row_group[t]) arcs.push_back({6'(t), 6'(h)});
      if (arcs.size() != 0 && $urandom_range(0, 4) == 0)
        arcs.push_back(arcs[$urandom_range(0, arcs.size() - 1)]);
      if ($urandom_range(0, 4) == 0)
        arcs.push_back({6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1))});
    end
    if (n < 64 && $urandom_range(0, 3) == 0) begin
      a = 6'($urandom_range(n, 63));
      b = 6'($urandom);
      arcs.push_back($urandom_range(0, 1) ? {a, b} : {b, a});
    end
    for (int i = arcs.size() - 1; i > 0; i--) begin
      k       = $urandom_range(0, i);
      tmp     = arcs[i];
      arcs[i] = arcs[k];
      arcs[k] = tmp;
    end
    foreach (arcs[i]) begin
      if ($urandom_range(0, 39) == 0) send_item(CMD_NONE, 6'($urandom), 6'($urandom));
      if ($urandom_range(0, 24) == 0)
        send_item(ldc_pkg::CMD_EVAL, 6'($urandom), 6'($urandom));
      send_item(ldc_pkg::CMD_ADD, arcs[i][11:6], arcs[i][5:0]);
    end
    send_item(ldc_pkg::CMD_EVAL, 6'($urandom), 6'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_item(ldc_pkg::CMD_EVAL, 6'($urandom), 6'($urandom));
  endtask

  initial begin
    int unsigned episode;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = ldc_pkg::VC_RESET;
    in_valid_i    = 1'b0;
    command_i     = ldc_pkg::CMD_CLEAR;
    tail_vertex_i = '0;
    head_vertex_i = '0;
    burst_left    = 0;
    sent_items    = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed_cases();

    sent_items = 0;
    episode    = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (episode % 5 == 0) write_vertex_count(pick_vertex_count());
      run_graph_episode();
      episode++;
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("** line_digraph_check: PASSED **");
    end else begin
      $display("** line_digraph_check: FAILED **");
    end
    $finish;
  end

endmodule
